>>> src/iosh_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// iosh_pkg
// Types and constants shared by the I/O size histogram table.
// ---------------------------------------------------------------------------
package iosh_pkg;

   localparam int BUCKETS  = 5;
   localparam int BUCKET_W = 3;
   localparam int SLOT_W   = 6;

   localparam logic [1:0] STATUS_RECORDED = 2'd0;
   localparam logic [1:0] STATUS_FULL     = 2'd1;
   localparam logic [1:0] STATUS_IGNORED  = 2'd2;
   localparam logic [1:0] STATUS_CLEARED  = 2'd3;

   localparam logic [1:0] DEV_EMMC = 2'd0;
   localparam logic [1:0] DEV_SD   = 2'd1;
   localparam logic [1:0] DEV_FUSE = 2'd2;

   localparam logic [1:0] KIND_RECORD = 2'd0;
   localparam logic [1:0] KIND_IGNORE = 2'd1;
   localparam logic [1:0] KIND_CLEAR  = 2'd2;

   localparam logic [1:0] CSR_LIMIT_SMALL  = 2'd0;
   localparam logic [1:0] CSR_LIMIT_PAGE   = 2'd1;
   localparam logic [1:0] CSR_LIMIT_MEDIUM = 2'd2;
   localparam logic [1:0] CSR_LIMIT_LARGE  = 2'd3;

   localparam logic [31:0] RESET_LIMIT_SMALL  = 32'd1024;
   localparam logic [31:0] RESET_LIMIT_PAGE   = 32'd4096;
   localparam logic [31:0] RESET_LIMIT_MEDIUM = 32'd131072;
   localparam logic [31:0] RESET_LIMIT_LARGE  = 32'd524288;

   typedef struct packed {
      logic        req_type;
      logic        is_write;
      logic [31:0] byte_count;
      logic [31:0] elapsed_ticks;
      logic [63:0] task_key;
      logic [21:0] task_id;
      logic        via_fuse;
      logic        has_disk;
      logic        primary_disk;
   } req_item_type;

   typedef struct packed {
      logic [1:0]          status;
      logic [SLOT_W-1:0]   slot;
      logic [BUCKET_W-1:0] bucket;
      logic                new_entry;
      logic [31:0]         bucket_count;
      logic [31:0]         bucket_bytes;
      logic [31:0]         total_time;
      logic [31:0]         full_errors;
   } rsp_item_type;

   typedef struct packed {
      logic [1:0]          kind;
      logic [1:0]          dev;
      logic [BUCKET_W-1:0] bucket;
      logic                is_write;
      logic [31:0]         byte_count;
      logic [31:0]         elapsed_ticks;
      logic [63:0]         task_key;
      logic [21:0]         task_id;
   } work_item_type;

endpackage

>>> src/iosh_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// iosh_ram
// Generic single-write, single-read memory with a registered read.
// ---------------------------------------------------------------------------
module iosh_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/iosh_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// iosh_front
// Accepts request beats, resolves device and size bucket, and queues the
// classified work for the back end in a two-entry queue.
// ---------------------------------------------------------------------------
module iosh_front #(
   parameter int DEVICES = 3
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  iosh_pkg::req_item_type req_data,
   input  logic                   csr_valid,
   input  logic [1:0]             csr_index,
   input  logic [31:0]            csr_data,
   input  logic                   pop,
   output logic                   q_valid,
   output iosh_pkg::work_item_type q_data
);

   logic [31:0] limit_small_ff, limit_page_ff, limit_medium_ff, limit_large_ff;
   iosh_pkg::work_item_type q_mem_ff [2];
   logic                    wr_ptr_ff, rd_ptr_ff;
   logic [1:0]              count_ff;
   iosh_pkg::work_item_type item;
   logic                    push;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_small_ff  <= iosh_pkg::RESET_LIMIT_SMALL;
         limit_page_ff   <= iosh_pkg::RESET_LIMIT_PAGE;
         limit_medium_ff <= iosh_pkg::RESET_LIMIT_MEDIUM;
         limit_large_ff  <= iosh_pkg::RESET_LIMIT_LARGE;
      end else if (csr_valid) begin
         unique case (csr_index)
            iosh_pkg::CSR_LIMIT_SMALL:  limit_small_ff  <= csr_data;
            iosh_pkg::CSR_LIMIT_PAGE:   limit_page_ff   <= csr_data;
            iosh_pkg::CSR_LIMIT_MEDIUM: limit_medium_ff <= csr_data;
            iosh_pkg::CSR_LIMIT_LARGE:  limit_large_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      item               = '0;
      item.is_write      = req_data.is_write;
      item.byte_count    = req_data.byte_count;
      item.elapsed_ticks = req_data.elapsed_ticks;
      item.task_key      = req_data.task_key;
      item.task_id       = req_data.task_id;
      if (req_data.via_fuse) begin
         item.dev = iosh_pkg::DEV_FUSE;
      end else if (req_data.primary_disk) begin
         item.dev = iosh_pkg::DEV_EMMC;
      end else begin
         item.dev = iosh_pkg::DEV_SD;
      end
      priority if (req_data.req_type) begin
         item.kind = iosh_pkg::KIND_CLEAR;
      end else if (!req_data.via_fuse && !req_data.has_disk) begin
         item.kind = iosh_pkg::KIND_IGNORE;
      end else if (32'(item.dev) >= 32'(DEVICES)) begin
         item.kind = iosh_pkg::KIND_IGNORE;
      end else begin
         item.kind = iosh_pkg::KIND_RECORD;
      end
      priority if (req_data.byte_count <= limit_small_ff) begin
         item.bucket = 3'd0;
      end else if (req_data.byte_count <= limit_page_ff) begin
         item.bucket = 3'd1;
      end else if (req_data.byte_count <= limit_medium_ff) begin
         item.bucket = 3'd2;
      end else if (req_data.byte_count <= limit_large_ff) begin
         item.bucket = 3'd3;
      end else begin
         item.bucket = 3'd4;
      end
   end

   assign req_stall = (count_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != 2'd0);
   assign q_data    = q_mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[wr_ptr_ff] <= item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         count_ff <= count_ff + 2'(push) - 2'(pop);
      end
   end

endmodule

>>> src/iosh_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// iosh_back
// Executes queued work: walks the filled slots of a device table, claims
// and zeroes a new slot, updates the counters and registers the response.
// ---------------------------------------------------------------------------
module iosh_back #(
   parameter int SLOTS   = 64,
   parameter int DEVICES = 3
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    q_valid,
   input  iosh_pkg::work_item_type q_data,
   output logic                    pop,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output iosh_pkg::rsp_item_type  rsp_data
);

   localparam int SW  = $clog2(SLOTS);
   localparam int DW  = (DEVICES > 1) ? $clog2(DEVICES) : 1;
   localparam int RW  = DW + SW;
   localparam int KEY_DEPTH  = 2 ** RW;
   localparam int CNT_DEPTH  = 2 ** (RW + 4);
   localparam int TIME_DEPTH = 2 ** (RW + 1);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SEARCH = 3'd1;
   localparam logic [2:0] ST_KEY    = 3'd2;
   localparam logic [2:0] ST_ZERO   = 3'd3;
   localparam logic [2:0] ST_READ   = 3'd4;
   localparam logic [2:0] ST_WRITE  = 3'd5;

   logic [2:0]              state_ff, state_in;
   iosh_pkg::work_item_type cur_ff, cur_in;
   logic [SW:0]             s_ff, s_in;
   logic [3:0]              z_ff, z_in;
   logic                    fresh_ff, fresh_in;
   logic [SW:0]             fill_ff [DEVICES];
   logic [SW:0]             fill_in [DEVICES];
   logic [31:0]             err_ff, err_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   iosh_pkg::rsp_item_type  rsp_ff, rsp_in;

   logic              out_free;
   logic [DW-1:0]     dev_ix;
   logic [RW-1:0]     row;
   logic [SW:0]       fill_cur;

   logic              key_we, key_re;
   logic [85:0]       key_rd;
   logic              cnt_we, cnt_re;
   logic [RW+3:0]     cnt_waddr;
   logic [63:0]       cnt_wdata, cnt_rd;
   logic              time_we, time_re;
   logic [RW:0]       time_waddr;
   logic [31:0]       time_wdata, time_rd;
   logic [31:0]       new_count, new_bytes, new_time;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign dev_ix   = DW'(cur_ff.dev);
   assign row      = {dev_ix, s_ff[SW-1:0]};
   assign fill_cur = fill_ff[dev_ix];

   assign new_count = cnt_rd[31:0] + 32'd1;
   assign new_bytes = cnt_rd[63:32] + cur_ff.byte_count;
   assign new_time  = time_rd + cur_ff.elapsed_ticks;

   iosh_ram #(.WIDTH(86), .DEPTH(KEY_DEPTH)) u_key_ram (
      .clock   (clock),
      .wr_en   (key_we),
      .wr_addr (row),
      .wr_data ({cur_ff.task_id, cur_ff.task_key}),
      .rd_en   (key_re),
      .rd_addr (row),
      .rd_data (key_rd)
   );

   iosh_ram #(.WIDTH(64), .DEPTH(CNT_DEPTH)) u_cnt_ram (
      .clock   (clock),
      .wr_en   (cnt_we),
      .wr_addr (cnt_waddr),
      .wr_data (cnt_wdata),
      .rd_en   (cnt_re),
      .rd_addr ({row, cur_ff.is_write, cur_ff.bucket}),
      .rd_data (cnt_rd)
   );

   iosh_ram #(.WIDTH(32), .DEPTH(TIME_DEPTH)) u_time_ram (
      .clock   (clock),
      .wr_en   (time_we),
      .wr_addr (time_waddr),
      .wr_data (time_wdata),
      .rd_en   (time_re),
      .rd_addr ({row, cur_ff.is_write}),
      .rd_data (time_rd)
   );

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      s_in         = s_ff;
      z_in         = z_ff;
      fresh_in     = fresh_ff;
      fill_in      = fill_ff;
      err_in       = err_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      pop          = 1'b0;
      key_we       = 1'b0;
      key_re       = 1'b0;
      cnt_we       = 1'b0;
      cnt_re       = 1'b0;
      cnt_waddr    = {row, z_ff};
      cnt_wdata    = '0;
      time_we      = 1'b0;
      time_re      = 1'b0;
      time_waddr   = {row, z_ff[3]};
      time_wdata   = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid && out_free) begin
               pop    = 1'b1;
               cur_in = q_data;
               unique case (q_data.kind)
                  iosh_pkg::KIND_CLEAR: begin
                     rsp_valid_in       = 1'b1;
                     rsp_in             = '0;
                     rsp_in.status      = iosh_pkg::STATUS_CLEARED;
                     rsp_in.full_errors = err_ff;
                     err_in             = '0;
                     for (int d = 0; d < DEVICES; d++) begin
                        fill_in[d] = '0;
                     end
                  end
                  iosh_pkg::KIND_RECORD: begin
                     s_in     = '0;
                     state_in = ST_SEARCH;
                  end
                  default: begin
                     rsp_valid_in       = 1'b1;
                     rsp_in             = '0;
                     rsp_in.status      = iosh_pkg::STATUS_IGNORED;
                     rsp_in.full_errors = err_ff;
                  end
               endcase
            end
         end
         ST_SEARCH: begin
            if (s_ff == fill_cur) begin
               if (fill_cur == (SW+1)'(SLOTS)) begin
                  if (out_free) begin
                     err_in             = err_ff + 32'd1;
                     rsp_valid_in       = 1'b1;
                     rsp_in             = '0;
                     rsp_in.status      = iosh_pkg::STATUS_FULL;
                     rsp_in.bucket      = cur_ff.bucket;
                     rsp_in.full_errors = err_ff + 32'd1;
                     state_in           = ST_IDLE;
                  end
               end else begin
                  fresh_in = 1'b1;
                  z_in     = '0;
                  state_in = ST_ZERO;
               end
            end else begin
               key_re   = 1'b1;
               state_in = ST_KEY;
            end
         end
         ST_KEY: begin
            if (key_rd[63:0] == cur_ff.task_key) begin
               fresh_in = 1'b0;
               state_in = ST_READ;
            end else begin
               s_in     = s_ff + 1'b1;
               state_in = ST_SEARCH;
            end
         end
         ST_ZERO: begin
            cnt_we  = 1'b1;
            time_we = (z_ff[2:0] == 3'd0);
            z_in    = z_ff + 4'd1;
            if (z_ff == 4'hF) begin
               key_we          = 1'b1;
               fill_in[dev_ix] = fill_cur + 1'b1;
               state_in        = ST_READ;
            end
         end
         ST_READ: begin
            cnt_re   = 1'b1;
            time_re  = 1'b1;
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            cnt_waddr  = {row, cur_ff.is_write, cur_ff.bucket};
            time_waddr = {row, cur_ff.is_write};
            cnt_wdata  = {new_bytes, new_count};
            time_wdata = new_time;
            if (out_free) begin
               cnt_we              = 1'b1;
               time_we             = 1'b1;
               rsp_valid_in        = 1'b1;
               rsp_in.status       = iosh_pkg::STATUS_RECORDED;
               rsp_in.slot         = iosh_pkg::SLOT_W'(s_ff);
               rsp_in.bucket       = cur_ff.bucket;
               rsp_in.new_entry    = fresh_ff;
               rsp_in.bucket_count = new_count;
               rsp_in.bucket_bytes = new_bytes;
               rsp_in.total_time   = new_time;
               rsp_in.full_errors  = err_ff;
               state_in            = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         err_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int d = 0; d < DEVICES; d++) begin
            fill_ff[d] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
         fill_ff      <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff   <= cur_in;
      s_ff     <= s_in;
      z_ff     <= z_in;
      fresh_ff <= fresh_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> src/io_size_histogram_table.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// io_size_histogram_table
// Per-task I/O size histogram counters for three device tables.
//
// Request beats (req_valid, req_stall, req_data) carry either an I/O event
// to record or a clear command. Every request produces exactly one response
// beat on rsp_valid, rsp_stall and rsp_data. The four size limits are
// written through csr_valid, csr_ready, csr_index and csr_data, by the user
// only while the block is idle; the block itself does not enforce this.
// csr_ready is always high. A front end classifies each request and queues
// it (two entries); the back end then executes it. A clear or an ignored
// event passes the queue and the response register before it can be taken
// on the response side. A recorded event walks the occupied slots in the
// key memory, zeroes the counters of a newly claimed slot, then reads and
// writes its counters. The slot walk through the key memory sets the rate.
// Reset empties every table by clearing the per-device fill counts, zeroes
// the error count and restores the limits; no clearing pass is needed.
// While rsp_stall is high the response is held and the queue fills, after
// which req_stall rises.
// ---------------------------------------------------------------------------
module io_size_histogram_table #(
   parameter int SLOTS   = 64,
   parameter int DEVICES = 3
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  iosh_pkg::req_item_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output iosh_pkg::rsp_item_type rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [1:0]             csr_index,
   input  logic [31:0]            csr_data
);

   logic                    q_valid;
   logic                    q_pop;
   iosh_pkg::work_item_type q_data;

   assign csr_ready = 1'b1;

   iosh_front #(.DEVICES(DEVICES)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .csr_valid (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .pop       (q_pop),
      .q_valid   (q_valid),
      .q_data    (q_data)
   );

   iosh_back #(.SLOTS(SLOTS), .DEVICES(DEVICES)) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_data    (q_data),
      .pop       (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

>>> src/iosh_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// iosh_checker
// Port-level checks for the I/O size histogram table, bound to the top.
// ---------------------------------------------------------------------------
module iosh_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input iosh_pkg::rsp_item_type rsp_data
);

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response beat dropped while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_data))
      else $error("stalled response beat changed");

   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response beat present after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == iosh_pkg::STATUS_IGNORED
                    || rsp_data.status == iosh_pkg::STATUS_CLEARED)
      |-> rsp_data.slot == '0 && rsp_data.bucket == '0 && !rsp_data.new_entry
          && rsp_data.bucket_count == '0 && rsp_data.total_time == '0)
      else $error("ignored or cleared beat carries counter data");

endmodule

bind io_size_histogram_table iosh_checker u_iosh_checker (.*);

>>> sim/tb_io_size_histogram_table.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_io_size_histogram_table
// Self-checking bench for the per-task I/O size histogram table.
//
// A directed table covers reset limits, bucket edges, every device choice,
// the no-disk and clear cases and a full table. Random phases follow under
// several limit settings, mostly on a small pool of task keys so that slots
// are reused, with some phases that fill a table. Every response beat is
// compared with a prediction kept in the bench's own copy of the tables.
// ---------------------------------------------------------------------------
module tb_io_size_histogram_table;

   localparam int NSLOT = 64;
   localparam int NDEV  = 3;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   iosh_pkg::req_item_type req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   iosh_pkg::rsp_item_type rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [1:0]             csr_index = '0;
   logic [31:0]            csr_data = '0;

   io_size_histogram_table dut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Bench copy of the histogram state.
   logic [31:0] lim [4];
   logic        tab_used  [NDEV][NSLOT];
   logic [63:0] tab_key   [NDEV][NSLOT];
   logic [31:0] hist_cnt  [NDEV][NSLOT][2][iosh_pkg::BUCKETS];
   logic [31:0] hist_byt  [NDEV][NSLOT][2][iosh_pkg::BUCKETS];
   logic [31:0] tick_sum  [NDEV][NSLOT][2];
   logic [31:0] overflow_count;

   iosh_pkg::rsp_item_type pending_rsp[$];
   int                     failures = 0;
   logic                   quiet = 1'b0;
   logic                   hold_rsp = 1'b0;

   function automatic void empty_tables();
      for (int d = 0; d < NDEV; d++)
         for (int s = 0; s < NSLOT; s++) begin
            tab_used[d][s] = 1'b0;
            tab_key[d][s]  = '0;
            for (int w = 0; w < 2; w++) begin
               tick_sum[d][s][w] = '0;
               for (int b = 0; b < iosh_pkg::BUCKETS; b++) begin
                  hist_cnt[d][s][w][b] = '0;
                  hist_byt[d][s][w][b] = '0;
               end
            end
         end
   endfunction

   function automatic iosh_pkg::rsp_item_type histogram_update(iosh_pkg::req_item_type r);
      iosh_pkg::rsp_item_type o;
      int dev;
      int bk;
      int s;
      int hit;
      logic fresh;
      o = '0;
      hit = -1;
      fresh = 1'b0;
      if (r.req_type) begin
         o.status = iosh_pkg::STATUS_CLEARED;
         o.full_errors = overflow_count;
         empty_tables();
         overflow_count = '0;
         return o;
      end
      if (r.via_fuse) dev = iosh_pkg::DEV_FUSE;
      else if (!r.has_disk) dev = -1;
      else dev = r.primary_disk ? iosh_pkg::DEV_EMMC : iosh_pkg::DEV_SD;
      if (dev < 0) begin
         o.status = iosh_pkg::STATUS_IGNORED;
         o.full_errors = overflow_count;
         return o;
      end
      if (r.byte_count <= lim[0]) bk = 0;
      else if (r.byte_count <= lim[1]) bk = 1;
      else if (r.byte_count <= lim[2]) bk = 2;
      else if (r.byte_count <= lim[3]) bk = 3;
      else bk = 4;
      for (s = 0; s < NSLOT; s++) begin
         if (tab_used[dev][s] && tab_key[dev][s] == r.task_key) begin
            hit = s;
            break;
         end
         if (!tab_used[dev][s]) begin
            hit = s;
            fresh = 1'b1;
            break;
         end
      end
      o.bucket = bk[iosh_pkg::BUCKET_W-1:0];
      if (hit < 0) begin
         overflow_count += 1;
         o.status = iosh_pkg::STATUS_FULL;
         o.full_errors = overflow_count;
         return o;
      end
      if (fresh) begin
         tab_used[dev][hit] = 1'b1;
         tab_key[dev][hit]  = r.task_key;
         for (int w = 0; w < 2; w++) begin
            tick_sum[dev][hit][w] = '0;
            for (int b = 0; b < iosh_pkg::BUCKETS; b++) begin
               hist_cnt[dev][hit][w][b] = '0;
               hist_byt[dev][hit][w][b] = '0;
            end
         end
      end
      hist_cnt[dev][hit][r.is_write][bk] += 1;
      hist_byt[dev][hit][r.is_write][bk] += r.byte_count;
      tick_sum[dev][hit][r.is_write] += r.elapsed_ticks;
      o.status = iosh_pkg::STATUS_RECORDED;
      o.slot = hit[iosh_pkg::SLOT_W-1:0];
      o.new_entry = fresh;
      o.bucket_count = hist_cnt[dev][hit][r.is_write][bk];
      o.bucket_bytes = hist_byt[dev][hit][r.is_write][bk];
      o.total_time = tick_sum[dev][hit][r.is_write];
      o.full_errors = overflow_count;
      return o;
   endfunction

   // The beat stays offered after acceptance until the next call or drain
   // replaces or withdraws it at the following falling edge.
   task automatic send_beat(iosh_pkg::req_item_type r);
      while (!quiet && $urandom_range(99) < 24) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      pending_rsp.push_back(histogram_update(r));
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_checked(iosh_pkg::req_item_type r, iosh_pkg::rsp_item_type want);
      iosh_pkg::rsp_item_type p;
      p = pending_rsp[pending_rsp.size() - 1];
      if (p !== want) begin
         $display("%0t: table row disagrees: expected %h, predicted %h", $time, want, p);
         failures++;
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(negedge clock);
      repeat (200) @(negedge clock);
   endtask

   task automatic write_limit(logic [1:0] idx, logic [31:0] v);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      lim[idx] = v;
      @(negedge clock);
   endtask

   task automatic set_limits(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                             logic [31:0] d);
      write_limit(iosh_pkg::CSR_LIMIT_SMALL, a);
      write_limit(iosh_pkg::CSR_LIMIT_PAGE, b);
      write_limit(iosh_pkg::CSR_LIMIT_MEDIUM, c);
      write_limit(iosh_pkg::CSR_LIMIT_LARGE, d);
      csr_valid <= 1'b0;
   endtask

   function automatic iosh_pkg::req_item_type make_event(logic [63:0] k, logic [31:0] n,
                                                         logic [1:0] dv);
      iosh_pkg::req_item_type r;
      r = '0;
      r.is_write      = $urandom_range(1);
      r.byte_count    = n;
      r.elapsed_ticks = $urandom;
      r.task_key      = k;
      r.task_id       = $urandom;
      r.has_disk      = 1'b1;
      r.via_fuse      = (dv == iosh_pkg::DEV_FUSE);
      r.primary_disk  = (dv == iosh_pkg::DEV_EMMC);
      if (dv == iosh_pkg::DEV_FUSE) begin
         r.has_disk = $urandom_range(1);
         r.primary_disk = $urandom_range(1);
      end
      return r;
   endfunction

   function automatic logic [31:0] random_size();
      case ($urandom_range(5))
         0: return $urandom;
         1: return lim[$urandom_range(3)] + $urandom_range(2) - 1;
         2: return $urandom_range(2);
         3: return 32'hFFFF_FFFF - $urandom_range(1);
         default: return $urandom_range(600000);
      endcase
   endfunction

   task automatic random_phase(int count, int keys, int clear_pct);
      iosh_pkg::req_item_type r;
      for (int i = 0; i < count; i++) begin
         r = make_event({$urandom, $urandom} & 64'hFFFF_FFFF_FFFF_FF00
                        | 64'($urandom_range(keys - 1)), random_size(),
                        $urandom_range(2));
         if ($urandom_range(99) < 6) r.has_disk = 1'b0;
         if ($urandom_range(99) < 6) r.via_fuse = 1'b0;
         if ($urandom_range(99) < clear_pct) r.req_type = 1'b1;
         if (keys <= 16) r.task_key[63:8] = '0;
         send_beat(r);
      end
   endtask

   // Response side: random stalls and checking at the rising edge.
   initial begin
      forever begin
         @(negedge clock);
         rsp_stall <= hold_rsp || (!quiet && $urandom_range(99) < 24);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected beat, actual %h", $time, rsp_data);
            failures++;
         end else begin
            iosh_pkg::rsp_item_type w;
            w = pending_rsp.pop_front();
            if (rsp_data.status !== w.status || rsp_data.slot !== w.slot ||
                rsp_data.bucket !== w.bucket || rsp_data.new_entry !== w.new_entry ||
                rsp_data.bucket_count !== w.bucket_count ||
                rsp_data.bucket_bytes !== w.bucket_bytes ||
                rsp_data.total_time !== w.total_time ||
                rsp_data.full_errors !== w.full_errors) begin
               $display("%0t: mismatch, expected %h, actual %h", $time, w, rsp_data);
               failures++;
            end
         end
      end
   end

   typedef struct {
      iosh_pkg::req_item_type r;
      logic                   known;
      iosh_pkg::rsp_item_type want;
   } table_row_type;

   function automatic iosh_pkg::req_item_type rec(logic t, logic w, logic [31:0] n,
                                                  logic [31:0] tk, logic [63:0] k,
                                                  logic [21:0] id, logic f, logic d,
                                                  logic p);
      iosh_pkg::req_item_type r;
      r = {t, w, n, tk, k, id, f, d, p};
      return r;
   endfunction

   function automatic iosh_pkg::rsp_item_type res(logic [1:0] st, logic [5:0] sl,
                                                  logic [2:0] b, logic ne,
                                                  logic [31:0] c, logic [31:0] by,
                                                  logic [31:0] tt, logic [31:0] fe);
      iosh_pkg::rsp_item_type o;
      o = {st, sl, b, ne, c, by, tt, fe};
      return o;
   endfunction

   initial begin
      table_row_type rows[$];
      table_row_type row;

      lim[0] = iosh_pkg::RESET_LIMIT_SMALL;
      lim[1] = iosh_pkg::RESET_LIMIT_PAGE;
      lim[2] = iosh_pkg::RESET_LIMIT_MEDIUM;
      lim[3] = iosh_pkg::RESET_LIMIT_LARGE;
      empty_tables();
      overflow_count = '0;

      rows = '{
         '{rec(0, 0, 0, 5, 64'h0, 0, 0, 1, 1), 1,
           res(iosh_pkg::STATUS_RECORDED, 0, 0, 1, 1, 0, 5, 0)},
         '{rec(0, 0, 1024, 7, 64'h0, 1, 0, 1, 1), 1,
           res(iosh_pkg::STATUS_RECORDED, 0, 0, 0, 2, 1024, 12, 0)},
         '{rec(0, 1, 1025, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 22'h3FFFFF, 0, 1, 1),
           1, res(iosh_pkg::STATUS_RECORDED, 1, 1, 1, 1, 1025, 32'hFFFF_FFFF, 0)},
         '{rec(0, 1, 4096, 1, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 1, 1), 1,
           res(iosh_pkg::STATUS_RECORDED, 1, 1, 0, 2, 5121, 0, 0)},
         '{rec(0, 0, 4097, 3, 64'h1, 2, 0, 1, 0), 1,
           res(iosh_pkg::STATUS_RECORDED, 0, 2, 1, 1, 4097, 3, 0)},
         '{rec(0, 0, 131072, 3, 64'h1, 2, 0, 1, 0), 0, '0},
         '{rec(0, 0, 131073, 3, 64'h1, 2, 1, 0, 0), 1,
           res(iosh_pkg::STATUS_RECORDED, 0, 3, 1, 1, 131073, 3, 0)},
         '{rec(0, 0, 524288, 3, 64'h1, 2, 1, 1, 1), 0, '0},
         '{rec(0, 0, 524289, 9, 64'h2, 2, 1, 1, 0), 0, '0},
         '{rec(0, 1, 32'hFFFF_FFFF, 9, 64'h2, 2, 1, 1, 0), 0, '0},
         '{rec(0, 1, 100, 9, 64'h5, 2, 0, 0, 1), 1,
           res(iosh_pkg::STATUS_IGNORED, 0, 0, 0, 0, 0, 0, 0)},
         '{rec(0, 0, 100, 9, 64'h5, 2, 0, 0, 0), 1,
           res(iosh_pkg::STATUS_IGNORED, 0, 0, 0, 0, 0, 0, 0)},
         '{rec(1, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '1, '1, 1, 1, 1), 1,
           res(iosh_pkg::STATUS_CLEARED, 0, 0, 0, 0, 0, 0, 0)},
         '{rec(0, 0, 10, 4, 64'h0, 0, 0, 1, 1), 1,
           res(iosh_pkg::STATUS_RECORDED, 0, 0, 1, 1, 10, 4, 0)}
      };

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (rows[i]) begin
         row = rows[i];
         send_beat(row.r);
         if (row.known) send_checked(row.r, row.want);
      end

      // Fill the SD table, then overflow it and clear.
      quiet = 1'b1;
      for (int k = 0; k < NSLOT + 3; k++)
         send_beat(make_event(64'h1000 + k, 64, iosh_pkg::DEV_SD));
      quiet = 1'b0;
      send_beat(rec(1, 0, 0, 0, 0, 0, 0, 0, 0));
      drain();

      set_limits(32'd0, 32'd0, 32'd0, 32'd0);
      random_phase(150, 8, 1);
      drain();
      set_limits(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      random_phase(100, 8, 1);
      drain();
      set_limits(32'd5000, 32'd100, 32'd70000, 32'd20);
      random_phase(150, 16, 2);
      drain();

      // Long receiver hold-off while requests keep coming.
      fork
         begin
            hold_rsp = 1'b1;
            repeat (300) @(negedge clock);
            hold_rsp = 1'b0;
         end
         random_phase(40, 8, 0);
      join
      drain();

      set_limits(iosh_pkg::RESET_LIMIT_SMALL, iosh_pkg::RESET_LIMIT_PAGE,
                 iosh_pkg::RESET_LIMIT_MEDIUM, iosh_pkg::RESET_LIMIT_LARGE);
      quiet = 1'b1;
      random_phase(200, 8, 1);
      quiet = 1'b0;
      random_phase(300, 12, 1);
      random_phase(250, 90, 1);
      random_phase(150, 4096, 0);
      drain();

      if (failures == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

   initial begin
      #20_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
